// ===== sv/stks_pkg.sv =====
`default_nettype none
package stks_pkg;

  // Table size and field widths.
  localparam int MAX_KEEP = 16;
  localparam int KEEP_W = 5;
  localparam int POS_W = 16;
  localparam int SCORE_W = 32;
  localparam logic [POS_W-1:0] COUNTER_TOP = 16'hFFFF;

  // One input word: a score and the end-of-vector mark.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic final_element;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [KEEP_W-1:0] rank;
    logic [POS_W-1:0] position;
    logic signed [SCORE_W-1:0] kept_score;
    logic run_end;
  } out_word_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic last;
    logic emit;
    logic [KEEP_W-1:0] rank;
    logic run_end;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KEEP_W-1:0] fill_next;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/stks_datapath.sv =====
`default_nettype none
module stks_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire stks_pkg::in_word_t item,
  input  wire logic [stks_pkg::KEEP_W-1:0] keep_count,
  input  wire stks_pkg::dp_cmd_t cmd,
  output stks_pkg::dp_status_t status,
  output stks_pkg::out_word_t result,
  output logic strobe
);

  logic signed [stks_pkg::SCORE_W-1:0] slot_score [stks_pkg::MAX_KEEP];
  logic [stks_pkg::POS_W-1:0] slot_pos [stks_pkg::MAX_KEEP];
  logic [stks_pkg::KEEP_W-1:0] filled;
  logic [stks_pkg::KEEP_W-1:0] filled_next;
  logic [stks_pkg::POS_W-1:0] position;
  logic [stks_pkg::KEEP_W-1:0] k_eff;
  logic [stks_pkg::KEEP_W-1:0] fill_eff;
  logic [stks_pkg::MAX_KEEP-1:0] take;

  // Effective keep count and the fill level trimmed to it.
  always_comb begin
    if (keep_count > stks_pkg::KEEP_W'(stks_pkg::MAX_KEEP)) begin
      k_eff = stks_pkg::KEEP_W'(stks_pkg::MAX_KEEP);
    end else begin
      k_eff = keep_count;
    end
    fill_eff = (filled > k_eff) ? k_eff : filled;
  end

  // Each slot decides on its own whether the new word lands at or above it.
  always_comb begin
    for (int i = 0; i < stks_pkg::MAX_KEEP; i++) begin
      take[i] = (stks_pkg::KEEP_W'(i) < k_eff) &&
                ((stks_pkg::KEEP_W'(i) >= fill_eff) || (item.score > slot_score[i]));
    end
  end

  // Fill level after this word.
  always_comb begin
    if ((|take) && (fill_eff < k_eff)) begin
      filled_next = fill_eff + stks_pkg::KEEP_W'(1);
    end else begin
      filled_next = fill_eff;
    end
    status.fill_next = filled_next;
  end

  // Table: compare-and-shift on insert, shift toward the head while reporting.
  always_ff @(posedge clk) begin
    for (int i = 0; i < stks_pkg::MAX_KEEP; i++) begin
      if (cmd.insert) begin
        if (take[i] && ((i == 0) || !take[(i == 0) ? 0 : i - 1])) begin
          slot_score[i] <= item.score;
          slot_pos[i] <= position;
        end else if (take[i]) begin
          slot_score[i] <= slot_score[(i == 0) ? 0 : i - 1];
          slot_pos[i] <= slot_pos[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.emit && (i < stks_pkg::MAX_KEEP - 1)) begin
        slot_score[i] <= slot_score[(i < stks_pkg::MAX_KEEP - 1) ? i + 1 : i];
        slot_pos[i] <= slot_pos[(i < stks_pkg::MAX_KEEP - 1) ? i + 1 : i];
      end
    end
  end

  // Fill level and position counter; the final word clears both.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      position <= '0;
    end else if (cmd.insert) begin
      if (cmd.last) begin
        filled <= '0;
        position <= '0;
      end else begin
        filled <= filled_next;
        if (position != stks_pkg::COUNTER_TOP) begin
          position <= position + stks_pkg::POS_W'(1);
        end
      end
    end
  end

  // Result register, loaded from the head of the table.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.rank <= cmd.rank;
      result.position <= slot_pos[0];
      result.kept_score <= slot_score[0];
      result.run_end <= cmd.run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

endmodule
`default_nettype wire

// ===== sv/stks_controller.sv =====
`default_nettype none
module stks_controller (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic final_element,
  input  wire stks_pkg::dp_status_t status,
  output stks_pkg::dp_cmd_t cmd,
  output logic busy
);

  stks_pkg::ctrl_state_t state;
  stks_pkg::ctrl_state_t state_next;
  logic [stks_pkg::KEEP_W-1:0] total;
  logic [stks_pkg::KEEP_W-1:0] rank;
  logic accept;

  assign accept = start && (state == stks_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      stks_pkg::ST_IDLE: begin
        if (accept && final_element && (status.fill_next != '0)) begin
          state_next = stks_pkg::ST_REPORT;
        end
      end
      stks_pkg::ST_REPORT: begin
        if (rank == total) begin
          state_next = stks_pkg::ST_IDLE;
        end
      end
      default: state_next = stks_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd.insert = 1'b0;
    cmd.last = final_element;
    cmd.emit = 1'b0;
    cmd.rank = rank;
    cmd.run_end = (rank == total);
    busy = 1'b0;
    case (state)
      stks_pkg::ST_IDLE: begin
        cmd.insert = accept;
      end
      stks_pkg::ST_REPORT: begin
        cmd.emit = 1'b1;
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // State, report length and rank counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stks_pkg::ST_IDLE;
      total <= '0;
      rank <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        total <= status.fill_next;
        rank <= stks_pkg::KEEP_W'(1);
      end else if (state == stks_pkg::ST_REPORT) begin
        rank <= rank + stks_pkg::KEEP_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/streaming_top_k_selector.sv =====
// Flow: an element is taken at an edge where start is high and busy is low. If any element
// is kept, the edge that takes the final element moves the state machine to reporting; then
// the result register and strobe are loaded with one result per cycle, min(k, 16, n) in all.
// Elements: one per cycle while busy is low; busy stays high while the table shifts one word
// per cycle toward the result register. Reset clears the state machine, fill level, position
// counter and strobe; table contents are undefined until written. The receiver cannot stall results.
`default_nettype none
module streaming_top_k_selector (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire stks_pkg::in_word_t item,
  output logic busy,
  output stks_pkg::out_word_t result,
  output logic strobe,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [stks_pkg::KEEP_W-1:0] cfg_data
);

  stks_pkg::dp_cmd_t cmd;
  stks_pkg::dp_status_t status;
  logic [stks_pkg::KEEP_W-1:0] keep_count;

  assign cfg_ready = !busy;

  // Keep-count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      keep_count <= cfg_data;
    end
  end

  stks_controller u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .final_element(item.final_element),
    .status(status),
    .cmd(cmd),
    .busy(busy)
  );

  stks_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .item(item),
    .keep_count(keep_count),
    .cmd(cmd),
    .status(status),
    .result(result),
    .strobe(strobe)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles allowed after the last expected word before the block is taken as idle.
  localparam int SETTLE = 4;
  localparam int RANDOM_WORDS = 300;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    ROW_CONFIG,
    ROW_WORD
  } row_kind_t;

  // How the scores of one random vector are drawn.
  typedef enum int {
    SC_ANY,
    SC_TIES,
    SC_EDGES
  } score_style_t;

  // One row of directed stimulus. Typed rows carry their own expectation.
  typedef struct packed {
    row_kind_t kind;
    logic [stks_pkg::SCORE_W-1:0] data;
    logic fin;
    logic typed;
    logic [1:0] typed_count;
    logic [stks_pkg::POS_W-1:0] typed_pos;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  stks_pkg::in_word_t item;
  logic busy;
  stks_pkg::out_word_t result;
  logic strobe;
  logic cfg_valid;
  logic cfg_ready;
  logic [stks_pkg::KEEP_W-1:0] cfg_data;

  // Shadow of the block: the sorted table, the fill level and the position counter.
  logic signed [stks_pkg::SCORE_W-1:0] slot_val [stks_pkg::MAX_KEEP];
  logic [stks_pkg::POS_W-1:0] slot_at [stks_pkg::MAX_KEEP];
  int fill_count;
  logic [stks_pkg::POS_W-1:0] next_at;
  logic [stks_pkg::KEEP_W-1:0] keep_reg;

  stks_pkg::out_word_t pending_report[$];
  dir_row_t dir_rows[$];

  int mismatches = 0;
  int words_sent = 0;
  int vectors_done = 0;
  int results_seen = 0;
  logic [31:0] keep_seen = '0;
  bit steady = 1'b0;

  streaming_top_k_selector uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .result(result),
    .strobe(strobe),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Updates the shadow table with one element and queues the words that it reports.
  function automatic void track_element(input stks_pkg::in_word_t w, input bit record);
    int k;
    int slot;
    int top;
    int i;
    logic signed [stks_pkg::SCORE_W-1:0] s;
    stks_pkg::out_word_t r;
    k = (keep_reg > stks_pkg::MAX_KEEP) ? stks_pkg::MAX_KEEP : int'(keep_reg);
    s = w.score;
    if (fill_count > k) fill_count = k;
    slot = fill_count;
    while (slot > 0 && s > slot_val[slot-1]) slot--;
    if (slot < k) begin
      top = (fill_count < k) ? fill_count : k - 1;
      for (i = top; i > slot; i--) begin
        slot_val[i] = slot_val[i-1];
        slot_at[i] = slot_at[i-1];
      end
      slot_val[slot] = s;
      slot_at[slot] = next_at;
      if (fill_count < k) fill_count++;
    end
    if (next_at < stks_pkg::COUNTER_TOP) next_at++;
    if (w.final_element) begin
      for (i = 0; i < fill_count; i++) begin
        r.rank = stks_pkg::KEEP_W'(i + 1);
        r.position = slot_at[i];
        r.kept_score = slot_val[i];
        r.run_end = (i + 1 == fill_count);
        if (record) pending_report.push_back(r);
      end
      fill_count = 0;
      next_at = '0;
      vectors_done++;
    end
  endfunction

  function automatic logic [stks_pkg::SCORE_W-1:0] pick_score(input score_style_t style);
    case (style)
      SC_TIES: begin
        return stks_pkg::SCORE_W'(int'($urandom_range(0, 4)) - 2) << 16;
      end
      SC_EDGES: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return $urandom;
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Random pause of the sender, with start low and garbage on the word lines.
  task automatic idle_gap();
    stks_pkg::in_word_t junk;
    while (!steady && $urandom_range(0, 99) < 31) begin
      junk.score = $urandom;
      junk.final_element = 1'($urandom_range(0, 1));
      start <= 1'b0;
      item <= junk;
      @(posedge clk);
    end
  endtask

  // Presents one word and returns at the edge where it is taken.
  task automatic send_word(input stks_pkg::in_word_t w, input bit record);
    idle_gap();
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy);
    track_element(w, record);
    words_sent++;
  endtask

  // Holds the sender off until every expected word has come and the block has settled.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_report.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_keep(input logic [stks_pkg::KEEP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    keep_reg = value;
    keep_seen[value] = 1'b1;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Result checker: every strobed word is matched against the oldest expectation.
  always @(posedge clk) begin
    stks_pkg::out_word_t want;
    if (!rst && strobe) begin
      results_seen++;
      if (pending_report.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual rank %0d pos %0d score %0h",
                 $time, result.rank, result.position, result.kept_score);
        mismatches++;
      end else begin
        want = pending_report.pop_front();
        compare_field("rank", 32'(want.rank), 32'(result.rank));
        compare_field("position", 32'(want.position), 32'(result.position));
        compare_field("kept_score", want.kept_score, result.kept_score);
        compare_field("run_end", 32'(want.run_end), 32'(result.run_end));
      end
    end
  end

  // Stimulus: directed table, then random vectors under random settings.
  initial begin
    stks_pkg::in_word_t w;
    stks_pkg::out_word_t r;
    dir_row_t row;
    score_style_t style;
    int len;
    int nvec;
    int j;
    logic [stks_pkg::KEEP_W-1:0] pick;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fill_count = 0;
    next_at = '0;
    keep_reg = '0;

    // After reset k is zero: the element is counted, nothing is reported.
    dir_rows.push_back('{ROW_WORD, 32'h0005_0000, 1'b1, 1'b1, 2'd0, 16'd0});
    // Single-element vectors with the score extremes.
    dir_rows.push_back('{ROW_CONFIG, 32'd1, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h7FFF_FFFF, 1'b1, 1'b1, 2'd1, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h8000_0000, 1'b1, 1'b1, 2'd1, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0000_0000, 1'b1, 1'b1, 2'd1, 16'd0});
    // Six elements under a setting of 16, with equal scores and both extremes.
    dir_rows.push_back('{ROW_CONFIG, 32'd16, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0003_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0003_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h7FFF_FFFF, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h8000_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0003_0000, 1'b1, 1'b0, 2'd0, 16'd0});
    // An oversized setting acts as the table size.
    dir_rows.push_back('{ROW_CONFIG, 32'd31, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h1234_5678, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'hEDCB_A987, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h5555_5555, 1'b1, 1'b0, 2'd0, 16'd0});
    // The setting is lowered in the middle of a vector.
    dir_rows.push_back('{ROW_CONFIG, 32'd4, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0001_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0005_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0003_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0009_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0007_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_CONFIG, 32'd2, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h0002_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h000A_0000, 1'b1, 1'b0, 2'd0, 16'd0});
    // Zero setting: a longer vector reports nothing.
    dir_rows.push_back('{ROW_CONFIG, 32'd0, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'h4000_0000, 1'b0, 1'b0, 2'd0, 16'd0});
    dir_rows.push_back('{ROW_WORD, 32'hAAAA_AAAA, 1'b1, 1'b0, 2'd0, 16'd0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CONFIG) begin
        wait_idle();
        write_keep(row.data[stks_pkg::KEEP_W-1:0]);
      end else begin
        w.score = row.data;
        w.final_element = row.fin;
        send_word(w, !row.typed);
        if (row.typed && row.typed_count != 0) begin
          r.rank = stks_pkg::KEEP_W'(1);
          r.position = row.typed_pos;
          r.kept_score = row.data;
          r.run_end = 1'b1;
          pending_report.push_back(r);
        end
      end
    end

    // Random part: a new setting, then 1 to 4 well-formed vectors.
    while (words_sent < RANDOM_WORDS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: pick = 5'd0;
        1: pick = 5'd1;
        2: pick = 5'd16;
        3: pick = 5'd31;
        4: pick = 5'd17;
        default: pick = stks_pkg::KEEP_W'($urandom_range(0, 31));
      endcase
      write_keep(pick);
      nvec = $urandom_range(1, 4);
      repeat (nvec) begin
        style = score_style_t'($urandom_range(0, 2));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        steady = (words_sent >= 120 && words_sent < 180);
        for (j = 0; j < len; j++) begin
          if (j > 0 && $urandom_range(0, 99) < 4) begin
            wait_idle();
            write_keep(stks_pkg::KEEP_W'($urandom_range(0, 31)));
          end
          w.score = pick_score(style);
          w.final_element = (j == len - 1);
          send_word(w, 1'b1);
        end
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Run covered %0d words in %0d vectors, %0d result words, %0d keep settings,",
             words_sent, vectors_done, results_seen, $countones(keep_seen));
    $display("with ties, score extremes, zero and oversized settings and mid-vector changes.");
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing result words.
  initial begin
    #50_000_000;
    $display("Watchdog expired with %0d words still expected.", pending_report.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/stks_pkg.sv
sv/stks_datapath.sv
sv/stks_controller.sv
sv/streaming_top_k_selector.sv
tb/tb_top.sv
